### hdl/sst_pkg.sv
// Shared types and codes for the sorted set table.
package sst_pkg;

    localparam int SST_CAPACITY = 64;
    localparam int DATA_W = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } sst_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } sst_status_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } sst_ctl_t;

endpackage

### hdl/sst_cell.sv
// One storage cell of the sorted chain: compare against the key, shift on insert or remove.
module sst_cell
(
    input  logic                       clk,
    input  logic                       occ,
    input  logic signed [sst_pkg::DATA_W-1:0] key,
    input  sst_pkg::sst_ctl_t          ctl,
    input  logic                       lt_left,
    input  logic signed [sst_pkg::DATA_W-1:0] data_left,
    input  logic signed [sst_pkg::DATA_W-1:0] data_right,
    output logic signed [sst_pkg::DATA_W-1:0] data,
    output logic                       lt,
    output logic                       eq
);
    import sst_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    assign lt   = occ && (data_reg < key);
    assign eq   = occ && (data_reg == key);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins && !lt)
        begin
            data_next = lt_left ? key : data_left;
        end
        else if (ctl.rem && !lt)
        begin
            data_next = data_right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### hdl/sorted_set_table_top.sv
// Top level of the sorted set table: request staging, cell chain and result register.
//
// Usage:
//   Input channel: opcode and value with in_valid / in_stall. Opcode 0 inserts,
//   1 removes, 2 (and the unused code 3) only looks the value up.
//   Output channel: status, was_present and count with out_valid / out_stall,
//   one word per request, in request order.
//   Flow: an accepted request is held in op_reg / key_reg; its result is
//   registered when no result waits under out_stall. The chain of CAPACITY
//   cells compares every entry against the key combinationally and shifts at
//   the edge that registers the result, so while out_stall is low a new
//   request can be taken every cycle and throughput is one word per cycle.
//   Stall: while out_stall holds a waiting result, one more request is staged;
//   after that in_stall rises until the result is taken.
//   Reset: rst_n clears the element count and both valid flags; stored values
//   are not cleared, entries beyond the count are never read.
module sorted_set_table_top
#(
    parameter int CAPACITY = sst_pkg::SST_CAPACITY
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic signed [sst_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic                               was_present,
    output logic [sst_pkg::COUNT_OUT_W-1:0]    count
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic [1:0]               op_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               status_reg;
    logic                     present_reg;
    logic [COUNT_OUT_W-1:0]   count_reg;

    logic                     exec;
    logic                     accept;
    logic                     present;
    logic                     full;
    logic                     empty;
    logic [1:0]               st;
    sst_ctl_t                 ctl;
    sst_ctl_t                 ctl_cells;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

    logic [CAPACITY-1:0]      occ_vec;
    logic [CAPACITY-1:0]      lt_vec;
    logic [CAPACITY-1:0]      eq_vec;
    logic signed [DATA_W-1:0] data_vec [CAPACITY];

    assign exec     = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && !exec;
    assign accept   = in_valid && !in_stall;

    assign present = |eq_vec;
    assign full    = (cnt_reg == CNT_W'(CAPACITY));
    assign empty   = (cnt_reg == '0);

    always_comb
    begin
        st       = ST_OK;
        ctl      = '0;
        cnt_next = cnt_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (!present)
                begin
                    if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        ctl.ins  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (present)
                begin
                    ctl.rem  = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign ctl_cells = exec ? ctl : '0;
    assign cnt_wide  = {{COUNT_OUT_W{1'b0}}, cnt_next};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ_vec[gi] = (cnt_reg > CNT_W'(gi));
            if (gi == 0)
            begin : g_first
                sst_cell u_cell
                (
                    .clk        (clk),
                    .occ        (occ_vec[gi]),
                    .key        (key_reg),
                    .ctl        (ctl_cells),
                    .lt_left    (1'b1),
                    .data_left  (key_reg),
                    .data_right ((CAPACITY > 1) ? data_vec[(CAPACITY > 1) ? 1 : 0] : key_reg),
                    .data       (data_vec[gi]),
                    .lt         (lt_vec[gi]),
                    .eq         (eq_vec[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_last
                sst_cell u_cell
                (
                    .clk        (clk),
                    .occ        (occ_vec[gi]),
                    .key        (key_reg),
                    .ctl        (ctl_cells),
                    .lt_left    (lt_vec[gi-1]),
                    .data_left  (data_vec[gi-1]),
                    .data_right (key_reg),
                    .data       (data_vec[gi]),
                    .lt         (lt_vec[gi]),
                    .eq         (eq_vec[gi])
                );
            end
            else
            begin : g_mid
                sst_cell u_cell
                (
                    .clk        (clk),
                    .occ        (occ_vec[gi]),
                    .key        (key_reg),
                    .ctl        (ctl_cells),
                    .lt_left    (lt_vec[gi-1]),
                    .data_left  (data_vec[gi-1]),
                    .data_right (data_vec[gi+1]),
                    .data       (data_vec[gi]),
                    .lt         (lt_vec[gi]),
                    .eq         (eq_vec[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (exec)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= value;
        end
        if (exec)
        begin
            status_reg  <= st;
            present_reg <= present;
            count_reg   <= cnt_wide[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign was_present = present_reg;
    assign count       = count_reg;

endmodule

### tb/sorted_set_table_top_test.sv
// Testbench for sorted_set_table_top: directed table, then phased random traffic against a set model.
`timescale 1ns / 1ps

module sorted_set_table_top_test;
    import sst_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          POOL_SIZE    = 96;
    localparam logic [1:0]  OP_SPARE     = 2'd3;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]             status;
        logic                   was_present;
        logic [COUNT_OUT_W-1:0] count;
    } set_reply_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [DATA_W-1:0]      val;
        logic                   fixed;
        logic [1:0]             status;
        logic                   was_present;
        logic [COUNT_OUT_W-1:0] count;
    } table_row_t;

    localparam int ROWS = 24;
    localparam table_row_t DIRECTED [ROWS] = '{
        '{OP_LOOKUP, 32'd0,         1'b1, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, 32'd5,         1'b1, ST_EMPTY, 1'b0, 7'd0},
        '{OP_SPARE,  VAL_MIN,       1'b1, ST_OK,    1'b0, 7'd0},
        '{OP_INSERT, VAL_MIN,       1'b1, ST_OK,    1'b0, 7'd1},
        '{OP_INSERT, VAL_MAX,       1'b1, ST_OK,    1'b0, 7'd2},
        '{OP_INSERT, 32'd0,         1'b1, ST_OK,    1'b0, 7'd3},
        '{OP_INSERT, VAL_MAX,       1'b1, ST_OK,    1'b1, 7'd3},
        '{OP_LOOKUP, VAL_MIN,       1'b1, ST_OK,    1'b1, 7'd3},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, ST_OK,    1'b0, 7'd3},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_INSERT, 32'd1,         1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_INSERT, 32'h5555_5555, 1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_SPARE,  VAL_MAX,       1'b1, ST_OK,    1'b1, 7'd7},
        '{OP_REMOVE, 32'd42,        1'b1, ST_OK,    1'b0, 7'd7},
        '{OP_REMOVE, 32'd0,         1'b1, ST_OK,    1'b1, 7'd6},
        '{OP_REMOVE, VAL_MIN,       1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, VAL_MAX,       1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_LOOKUP, 32'd1,         1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, 32'd1,         1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, 32'h5555_5555, 1'b0, ST_OK,    1'b0, 7'd0},
        '{OP_REMOVE, 32'hAAAA_AAAA, 1'b1, ST_OK,    1'b1, 7'd0},
        '{OP_REMOVE, 32'd7,         1'b1, ST_EMPTY, 1'b0, 7'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic                     was_present;
    logic [COUNT_OUT_W-1:0]   count;

    logic signed [DATA_W-1:0] set_vals [SST_CAPACITY];
    int                       set_size;
    set_reply_t               reply_q [$];
    logic signed [DATA_W-1:0] pool [POOL_SIZE];
    int                       errors;
    int                       cycles;
    int                       stall_left;
    bit                       quiet;

    sorted_set_table_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .was_present (was_present),
        .count       (count)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic set_reply_t apply_request(logic [1:0] op, logic signed [DATA_W-1:0] v);
        int         pos;
        int         i;
        bit         hit;
        set_reply_t r;
        pos = 0;
        while (pos < set_size && set_vals[pos] < v)
            pos++;
        hit = (pos < set_size) && (set_vals[pos] == v);
        r.status = ST_OK;
        r.was_present = hit;
        case (op)
            OP_INSERT: begin
                if (!hit) begin
                    if (set_size >= SST_CAPACITY)
                        r.status = ST_FULL;
                    else begin
                        for (i = set_size; i > pos; i--)
                            set_vals[i] = set_vals[i-1];
                        set_vals[pos] = v;
                        set_size++;
                    end
                end
            end
            OP_REMOVE: begin
                if (set_size == 0)
                    r.status = ST_EMPTY;
                else if (hit) begin
                    for (i = pos; i + 1 < set_size; i++)
                        set_vals[i] = set_vals[i+1];
                    set_size--;
                end
            end
            default: ;
        endcase
        r.count = set_size[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // leaves the caller at the edge where the word was taken
    task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    always @(posedge clk) begin
        set_reply_t want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (reply_q.size() == 0) begin
                $error("unexpected word: status=%0d was_present=%0d count=%0d",
                       status, was_present, count);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (was_present !== want.was_present) begin
                    $error("was_present: expected %0d, got %0d", want.was_present, was_present);
                    errors++;
                end
                if (count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    errors++;
                end
            end
            stall_left = draw_wait();
        end else if (stall_left > 0)
            stall_left = stall_left - 1;
        out_stall <= (stall_left > 0);
    end

    initial begin
        set_reply_t               r;
        table_row_t               row;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] v;
        int                       sent;
        int                       kind;
        int                       len;
        int                       pick;
        int                       k;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        opcode     = OP_INSERT;
        value      = '0;
        errors     = 0;
        cycles     = 0;
        stall_left = 0;
        quiet      = 1'b0;
        set_size   = 0;

        pool[0] = VAL_MIN;
        pool[1] = VAL_MAX;
        pool[2] = 0;
        pool[3] = -1;
        pool[4] = 1;
        pool[5] = VAL_MIN + 1;
        pool[6] = VAL_MAX - 1;
        for (k = 7; k < POOL_SIZE; k++)
            pool[k] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < ROWS; k++) begin
            row = DIRECTED[k];
            send_word(row.op, row.val);
            r = apply_request(row.op, row.val);
            if (row.fixed) begin
                r.status      = row.status;
                r.was_present = row.was_present;
                r.count       = row.count;
            end
            reply_q.push_back(r);
        end

        // phases: 0 grow toward full, 1 drain to empty and past, 2 mixed, 3 wide values
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 3);
            len   = (kind < 2) ? $urandom_range(80, 160) : $urandom_range(30, 90);
            quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                case (kind)
                    0: op = (pick < 75) ? OP_INSERT : (pick < 85) ? OP_REMOVE :
                            (pick < 95) ? OP_LOOKUP : OP_SPARE;
                    1: op = (pick < 70) ? OP_REMOVE : (pick < 85) ? OP_INSERT :
                            (pick < 95) ? OP_LOOKUP : OP_SPARE;
                    default: op = (pick < 35) ? OP_INSERT : (pick < 70) ? OP_REMOVE :
                                  (pick < 90) ? OP_LOOKUP : OP_SPARE;
                endcase
                if (kind == 3 || $urandom_range(0, 9) == 0)
                    v = $urandom;
                else
                    v = pool[$urandom_range(0, POOL_SIZE - 1)];
                send_word(op, v);
                reply_q.push_back(apply_request(op, v));
                sent++;
            end
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
